### rtl/m10ufa_pkg.sv
package m10ufa_pkg;

    localparam int unsigned MAX_PIXELS = 4194304;
    localparam int unsigned IDX_W      = $clog2(MAX_PIXELS);
    localparam int unsigned ROW_W      = IDX_W - 1;
    localparam int unsigned ROWS       = MAX_PIXELS / 2;
    localparam int unsigned PIX_W      = 10;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned TOTAL_W    = 32;
    localparam int unsigned ACC_W      = PIX_W + CNT_W;
    localparam int unsigned DIV_W      = CNT_W + PIX_W - 1;
    localparam int unsigned IN_W       = 24;
    localparam int unsigned OUT_W      = 72;
    localparam int unsigned CFG_W      = 16;
    localparam int unsigned QSTEP_W    = $clog2(PIX_W);

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_MEAN   = 2'd1;
    localparam logic [1:0] MODE_PHOTO  = 2'd2;
    // spare encoding, behaves as normal unpack
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    localparam logic REG_MODE        = 1'b0;
    localparam logic REG_IMAGE_COUNT = 1'b1;

    localparam logic [7:0] MASK_LOW_A = 8'h03;
    localparam logic [7:0] MASK_LOW_B = 8'h30;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_a;
        logic [PIX_W-1:0]   pixel_b;
        logic [ROW_W-1:0]   row;
        logic [TOTAL_W-1:0] pixel_total;
        logic               frame_done;
        logic               is_mean;
        logic [CNT_W-1:0]   count;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_MUL,
        BK_DIV,
        BK_WB,
        BK_OUT
    } back_state_t;

endpackage

### rtl/m10ufa_front.sv
module m10ufa_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [m10ufa_pkg::CFG_W-1:0] cfg_data,
    input  logic                       push,
    input  logic [m10ufa_pkg::IN_W-1:0] in_data,
    input  logic                       in_last,
    output m10ufa_pkg::job_t           job
);
    import m10ufa_pkg::*;

    logic [1:0]         mode_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [7:0]         b0, b1, b2;
    logic [PIX_W-1:0]   pa, pb;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] sat;

    always_comb
    begin
        b0  = in_data[7:0];
        b1  = in_data[15:8];
        b2  = in_data[23:16];
        pa  = {b0, 2'b00} | {8'd0, b1[1:0] & MASK_LOW_A[1:0]};
        pb  = {b2, 2'b00} | {8'd0, 2'((b1 & MASK_LOW_B) >> 4)};
        sum = {1'b0, total_reg} + (TOTAL_W+1)'(pa) + (TOTAL_W+1)'(pb);
        sat = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];

        total_next = total_reg;
        idx_next   = idx_reg + IDX_W'(2);
        if (mode_reg == MODE_PHOTO)
            total_next = sat;
        if (in_last)
        begin
            total_next = '0;
            idx_next   = '0;
        end

        job.pixel_a     = pa;
        job.pixel_b     = pb;
        job.row         = idx_reg[IDX_W-1:1];
        job.pixel_total = (mode_reg == MODE_PHOTO) ? sat : '0;
        job.frame_done  = in_last;
        job.is_mean     = (mode_reg == MODE_MEAN);
        job.count       = (count_reg == '0) ? CNT_W'(1) : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            count_reg <= CNT_W'(1);
            idx_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MODE:        mode_reg  <= cfg_data[1:0];
                    REG_IMAGE_COUNT: count_reg <= cfg_data;
                    default:         ;
                endcase
            end
            if (push)
            begin
                idx_reg   <= idx_next;
                total_reg <= total_next;
            end
        end
    end

endmodule

### rtl/m10ufa_queue.sv
module m10ufa_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  m10ufa_pkg::job_t push_data,
    output logic             full,
    input  logic             pop,
    output m10ufa_pkg::job_t pop_data,
    output logic             empty
);
    import m10ufa_pkg::*;

    job_t       slot_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] fill_reg;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign pop_data = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= 1'b0;
            rd_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

### rtl/m10ufa_back.sv
module m10ufa_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  m10ufa_pkg::job_t            q_data,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [m10ufa_pkg::OUT_W-1:0] out_data,
    output logic                        out_last
);
    import m10ufa_pkg::*;

    back_state_t        state_reg, state_next;
    job_t               job_reg;
    logic [2*PIX_W-1:0] mem [ROWS];
    logic [2*PIX_W-1:0] rd_reg;
    logic [ACC_W-1:0]   rem_a_reg, rem_b_reg;
    logic [DIV_W-1:0]   div_reg;
    logic [PIX_W-1:0]   q_a_reg, q_b_reg;
    logic [QSTEP_W-1:0] step_reg;
    logic [OUT_W-1:0]   data_reg;
    logic               last_reg;
    logic [CNT_W-1:0]   nm1;
    logic [ACC_W-1:0]   prod_a, prod_b;
    logic               ge_a, ge_b;

    assign out_valid = (state_reg == BK_OUT);
    assign out_data  = data_reg;
    assign out_last  = last_reg;
    assign nm1       = job_reg.count - CNT_W'(1);
    assign ge_a      = rem_a_reg >= ACC_W'(div_reg);
    assign ge_b      = rem_b_reg >= ACC_W'(div_reg);

    // first image ignores the old value, which may never have been written
    always_comb
    begin
        prod_a = (nm1 == '0) ? '0 : ACC_W'(rd_reg[PIX_W-1:0]) * ACC_W'(nm1);
        prod_b = (nm1 == '0) ? '0 : ACC_W'(rd_reg[2*PIX_W-1:PIX_W]) * ACC_W'(nm1);
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = q_data.is_mean ? BK_READ : BK_OUT;
                end
            end
            BK_READ: state_next = BK_MUL;
            BK_MUL:  state_next = BK_DIV;
            BK_DIV:  state_next = (step_reg == '0) ? BK_WB : BK_DIV;
            BK_WB:   state_next = BK_OUT;
            BK_OUT:  state_next = out_ready ? BK_IDLE : BK_OUT;
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_READ)
            rd_reg <= mem[job_reg.row];
        if (state_reg == BK_WB)
            mem[job_reg.row] <= {q_b_reg, q_a_reg};
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    job_reg  <= q_data;
                    data_reg <= {q_data.pixel_total, {2*PIX_W{1'b0}},
                                 q_data.pixel_b, q_data.pixel_a};
                    last_reg <= q_data.frame_done;
                end
            end
            BK_MUL:
            begin
                rem_a_reg <= prod_a + ACC_W'(job_reg.pixel_a);
                rem_b_reg <= prod_b + ACC_W'(job_reg.pixel_b);
                div_reg   <= {job_reg.count, {(PIX_W-1){1'b0}}};
                step_reg  <= QSTEP_W'(PIX_W - 1);
            end
            BK_DIV:
            begin
                // restoring division, one quotient bit per lane a cycle
                if (ge_a)
                    rem_a_reg <= rem_a_reg - ACC_W'(div_reg);
                if (ge_b)
                    rem_b_reg <= rem_b_reg - ACC_W'(div_reg);
                q_a_reg  <= {q_a_reg[PIX_W-2:0], ge_a};
                q_b_reg  <= {q_b_reg[PIX_W-2:0], ge_b};
                div_reg  <= div_reg >> 1;
                step_reg <= step_reg - QSTEP_W'(1);
            end
            BK_WB:
                data_reg[4*PIX_W-1:2*PIX_W] <= {q_b_reg, q_a_reg};
            default: ;
        endcase
    end

endmodule

### rtl/mono10_unpack_frame_average_core.sv
// Mono10Packed group unpacker with per-pixel running mean and frame total.
// Input stream s_*: one three-byte packed group per transfer, tlast on the
// last group of a frame. Output stream m_*: one result per input group, in
// order, tlast copied from the input.
// Config port: cfg_we/cfg_index/cfg_data, index 0 = mode, 1 = image count.
// Write only while the block is idle.
// Between an input transfer and m_tvalid lie the queue slot and the
// output register in normal and photodetector modes; mean mode adds a
// memory read, multiply, a 10-step shared-lane divider and write-back.
// The back end works on one group at a time and pops the next group
// only after m_tready has taken the current result.
// A two-entry queue splits input handling from the back end, so s_tready
// stays high while a result waits for m_tready, until the queue fills.
// Reset sets mode to normal and image count to 1 and clears pixel index
// and running total; the frame store is not cleared and holds garbage until written.
module mono10_unpack_frame_average_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [m10ufa_pkg::CFG_W-1:0] cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // byte_first[7:0], byte_middle[15:8], byte_last[23:16]
    input  logic [m10ufa_pkg::IN_W-1:0] s_tdata,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // pixel_a[9:0], pixel_b[19:10], mean_a[29:20], mean_b[39:30],
    // pixel_total[71:40]
    output logic [m10ufa_pkg::OUT_W-1:0] m_tdata,
    output logic                        m_tlast
);
    import m10ufa_pkg::*;

    job_t push_job, pop_job;
    logic push, pop, full, empty;

    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    m10ufa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .job       (push_job)
    );

    m10ufa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_job),
        .empty     (empty)
    );

    m10ufa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (empty),
        .q_data    (pop_job),
        .q_pop     (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

### rtl/m10ufa_checker.sv
module m10ufa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [m10ufa_pkg::OUT_W-1:0] m_tdata,
    input logic                        m_tlast
);
    import m10ufa_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // mean and total fields never both carry data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[4*PIX_W-1:2*PIX_W] == '0) || (m_tdata[OUT_W-1:4*PIX_W] == '0))
        else $error("mean and total both set");

    // back end returns to idle after each transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("result repeated");

    // no result straight out of reset
    assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result during reset");

    // queue comes out of reset empty, so input is open
    assert property (@(posedge clk)
        !rst_n |=> s_tready)
        else $error("input blocked after reset");

endmodule

bind mono10_unpack_frame_average_core m10ufa_checker u_m10ufa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import m10ufa_pkg::*;

    localparam int unsigned IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_a;
        logic [PIX_W-1:0]   pixel_b;
        logic [PIX_W-1:0]   mean_a;
        logic [PIX_W-1:0]   mean_b;
        logic [TOTAL_W-1:0] pixel_total;
        logic               frame_done;
    } group_result_t;

    // Predicts unpacked groups and holds the expected results in order
    class pixel_scoreboard;
        logic [PIX_W-1:0]   avg_store [int unsigned];
        logic [IDX_W-1:0]   pos;
        logic [TOTAL_W-1:0] total;
        logic [1:0]         cur_mode;
        logic [CNT_W-1:0]   cur_count;
        group_result_t      pending [$];
        int                 errors;
        int                 checked;

        function new();
            pos = '0;
            total = '0;
            cur_mode = MODE_NORMAL;
            cur_count = CNT_W'(1);
            errors = 0;
            checked = 0;
        endfunction

        function logic [PIX_W-1:0] average(int unsigned slot, logic [PIX_W-1:0] pix,
                                           logic [CNT_W-1:0] n);
            logic [63:0] old;
            logic [63:0] acc;
            logic [PIX_W-1:0] res;
            old = avg_store.exists(slot) ? 64'(avg_store[slot]) : 64'd0;
            acc = old * 64'(n - 1) + 64'(pix);
            res = PIX_W'(acc / 64'(n));
            avg_store[slot] = res;
            return res;
        endfunction

        function void note_group(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic eof);
            group_result_t r;
            logic [CNT_W-1:0] n;
            logic [33:0] sum;
            r = '0;
            r.pixel_a = {b0, b1[1:0]};
            r.pixel_b = {b2, b1[5:4]};
            r.frame_done = eof;
            if (cur_mode == MODE_MEAN) begin
                n = (cur_count == 0) ? CNT_W'(1) : cur_count;
                r.mean_a = average(32'(pos), r.pixel_a, n);
                r.mean_b = average(32'(IDX_W'(pos + 1)), r.pixel_b, n);
            end else if (cur_mode == MODE_PHOTO) begin
                sum = 34'(total) + 34'(r.pixel_a) + 34'(r.pixel_b);
                total = sum[33:32] != 0 ? 32'hFFFF_FFFF : sum[31:0];
                r.pixel_total = total;
            end
            pending = {pending, r};
            if (eof) begin
                pos = '0;
                total = '0;
            end else begin
                pos = IDX_W'(pos + 2);
            end
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, checked);
        endtask

        task check_result(logic [OUT_W-1:0] data, logic last);
            group_result_t w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected transfer", data[63:0], 64'd0);
                return;
            end
            w = pending.pop_front();
            if (data[9:0] !== w.pixel_a)
                report_mismatch("pixel_a", 64'(data[9:0]), 64'(w.pixel_a));
            if (data[19:10] !== w.pixel_b)
                report_mismatch("pixel_b", 64'(data[19:10]), 64'(w.pixel_b));
            if (data[29:20] !== w.mean_a)
                report_mismatch("mean_a", 64'(data[29:20]), 64'(w.mean_a));
            if (data[39:30] !== w.mean_b)
                report_mismatch("mean_b", 64'(data[39:30]), 64'(w.mean_b));
            if (data[71:40] !== w.pixel_total)
                report_mismatch("pixel_total", 64'(data[71:40]), 64'(w.pixel_total));
            if (last !== w.frame_done)
                report_mismatch("frame_done", 64'(last), 64'(w.frame_done));
            checked++;
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tlast;

    pixel_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  idle_cycles;
    int  groups_sent;
    int  frames_sent;

    mono10_unpack_frame_average_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // receiver side: sample and check each result transfer, then redraw ready
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast);
            m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task write_reg(logic idx, logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_MODE) sb.cur_mode = val[1:0];
        else sb.cur_count = val;
    endtask

    task send_group(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic eof);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b2, b1, b0};
        s_tlast  <= eof;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_group(b0, b1, b2, eof);
        groups_sent++;
        if (eof) frames_sent++;
    endtask

    task drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task send_frame(int len);
        for (int i = 0; i < len; i++)
            send_group(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), i == len - 1);
    endtask

    // mean group over a short frame: image 1 writes every position first
    task mean_group(int len, int images);
        write_reg(REG_MODE, CFG_W'(MODE_MEAN));
        for (int k = 1; k <= images; k++) begin
            write_reg(REG_IMAGE_COUNT, (k == 1 && $urandom_range(1)) ? 16'd0 : CFG_W'(k));
            send_frame(len);
            drain();
        end
    endtask

    initial
    begin
        int mode_pick;
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        groups_sent = 0;
        frames_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes in normal mode, then the spare mode
        send_group(8'h00, 8'h00, 8'h00, 1'b0);
        send_group(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_group(8'hAA, 8'h55, 8'h55, 1'b0);
        send_group(8'h55, 8'hAA, 8'hAA, 1'b1);
        drain();
        write_reg(REG_MODE, CFG_W'(MODE_SPARE));
        send_group(8'hFF, 8'h33, 8'h01, 1'b1);
        drain();
        // photodetector, with a mode change mid frame
        write_reg(REG_MODE, CFG_W'(MODE_PHOTO));
        send_group(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_group(8'h80, 8'h11, 8'h7F, 1'b0);
        drain();
        write_reg(REG_MODE, CFG_W'(MODE_NORMAL));
        send_group(8'h12, 8'h34, 8'h56, 1'b0);
        drain();
        write_reg(REG_MODE, CFG_W'(MODE_PHOTO));
        send_group(8'hFF, 8'hFF, 8'hFF, 1'b1);
        drain();
        // mean: first image, then maximum image count, then image count zero
        write_reg(REG_MODE, CFG_W'(MODE_MEAN));
        write_reg(REG_IMAGE_COUNT, 16'd1);
        send_group(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_group(8'h00, 8'h00, 8'h00, 1'b1);
        drain();
        write_reg(REG_IMAGE_COUNT, 16'hFFFF);
        send_group(8'h00, 8'h00, 8'h00, 1'b0);
        send_group(8'hFF, 8'hFF, 8'hFF, 1'b1);
        drain();
        write_reg(REG_IMAGE_COUNT, 16'd0);
        send_group(8'h3C, 8'h21, 8'hC3, 1'b1);
        drain();

        // random phases: no idling, sender idle, receiver stalls, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 60 : (ph == 3) ? 22 : 0;
            recv_stall_pct = (ph == 2) ? 60 : (ph == 3) ? 22 : 0;
            while (groups_sent < 25 + 100 * (ph + 1)) begin
                mode_pick = $urandom_range(9);
                if (mode_pick < 4) begin
                    mean_group($urandom_range(1, 6), $urandom_range(1, 5));
                end else begin
                    write_reg(REG_MODE, CFG_W'(mode_pick < 7 ? MODE_PHOTO : MODE_NORMAL));
                    send_frame($urandom_range(1, 12));
                    drain();
                end
            end
        end

        // long receiver hold-off while the sender keeps offering groups
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(REG_MODE, CFG_W'(MODE_PHOTO));
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            send_frame(16);
        join
        drain();

        $display("covered %0d groups in %0d frames over normal, mean and photodetector modes,",
                 groups_sent, frames_sent);
        $display("with idle and stall phases and a long output hold-off; %0d results checked",
                 sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
